[hw/rtl/rcslot_pkg.sv]
// Shared types and constants for the reference-counted id slot table.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rcslot_pkg;

  // Field widths of the request and response words
  localparam int CMD_W    = 2;
  localparam int ID_W     = 31;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int LIVE_W   = 4;
  localparam int REFS_W   = 8;

  // Default table depth
  localparam int SLOTS_DEF = 8;

  // Saturation limits
  localparam logic [REFS_W-1:0] REFS_MAX = 8'd255;
  localparam logic [LIVE_W-1:0] LIVE_MAX = 4'd15;

  // Command codes; code 3 is unused and answers not found
  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_LOOKUP   = 2'd2
  } cmd_code_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_JOINED   = 3'd0,
    ST_CREATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DECR     = 3'd4,
    ST_FREED    = 3'd5,
    ST_HIT      = 3'd6
  } status_code_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ENCODE,
    S_READ,
    S_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic search;
    logic encode;
    logic read;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/rcslot_req_if.sv]
// Request channel: valid/ready handshake carrying one command word.
// Depends on rcslot_pkg for field widths.
interface rcslot_req_if;
  logic                              valid;
  logic                              ready;
  logic [rcslot_pkg::CMD_W-1:0]      cmd;
  logic [rcslot_pkg::ID_W-1:0]       id;
  logic                              flag;
  logic [rcslot_pkg::WORD_W-1:0]     vec_x;
  logic [rcslot_pkg::WORD_W-1:0]     vec_y;
  logic [rcslot_pkg::WORD_W-1:0]     vec_z;

  modport source (output valid, cmd, id, flag, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, cmd, id, flag, vec_x, vec_y, vec_z, output ready);
endinterface

[hw/rtl/rcslot_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result word.
// Depends on rcslot_pkg for field widths.
interface rcslot_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [rcslot_pkg::STATUS_W-1:0]   status;
  logic [rcslot_pkg::SLOT_W-1:0]     slot;
  logic                              flag_out;
  logic [rcslot_pkg::WORD_W-1:0]     out_x;
  logic [rcslot_pkg::WORD_W-1:0]     out_y;
  logic [rcslot_pkg::WORD_W-1:0]     out_z;
  logic [rcslot_pkg::LIVE_W-1:0]     live_ids;

  modport source (output valid, status, slot, flag_out, out_x, out_y, out_z, live_ids,
                  input ready);
  modport sink   (input valid, status, slot, flag_out, out_x, out_y, out_z, live_ids,
                  output ready);
endinterface

[hw/rtl/rcslot_ctrl.sv]
// Controller state machine of the slot table: steps one command word through
// search, encode, read and update. Depends on rcslot_pkg.
module rcslot_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rcslot_pkg::dp_status_t dp_status,
  output rcslot_pkg::dp_cmd_t    dp_cmd
);

  rcslot_pkg::state_t state;
  rcslot_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcslot_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rcslot_pkg::S_IDLE: begin
        if (in_valid) state_next = rcslot_pkg::S_SEARCH;
      end
      rcslot_pkg::S_SEARCH: state_next = rcslot_pkg::S_ENCODE;
      rcslot_pkg::S_ENCODE: state_next = rcslot_pkg::S_READ;
      rcslot_pkg::S_READ:   state_next = rcslot_pkg::S_UPDATE;
      rcslot_pkg::S_UPDATE: begin
        if (dp_status.out_free) state_next = rcslot_pkg::S_IDLE;
      end
      default: state_next = rcslot_pkg::S_IDLE;
    endcase
  end

  // Outputs: hold the update until the result register can take the word
  always_comb begin
    in_ready       = 1'b0;
    dp_cmd         = '0;
    case (state)
      rcslot_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        dp_cmd.capture = in_valid;
      end
      rcslot_pkg::S_SEARCH: dp_cmd.search = 1'b1;
      rcslot_pkg::S_ENCODE: dp_cmd.encode = 1'b1;
      rcslot_pkg::S_READ:   dp_cmd.read   = 1'b1;
      rcslot_pkg::S_UPDATE: dp_cmd.commit = dp_status.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/rcslot_dp.sv]
// Datapath of the slot table: key and used registers, parallel key compare,
// priority encode, slot memories and the result register. Depends on rcslot_pkg.
module rcslot_dp #(
  parameter int SLOTS = rcslot_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rcslot_pkg::dp_cmd_t               dp_cmd,
  output rcslot_pkg::dp_status_t            dp_status,
  input  logic [rcslot_pkg::CMD_W-1:0]      in_cmd,
  input  logic [rcslot_pkg::ID_W-1:0]       in_id,
  input  logic                              in_flag,
  input  logic [rcslot_pkg::WORD_W-1:0]     in_x,
  input  logic [rcslot_pkg::WORD_W-1:0]     in_y,
  input  logic [rcslot_pkg::WORD_W-1:0]     in_z,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [rcslot_pkg::STATUS_W-1:0]   out_status,
  output logic [rcslot_pkg::SLOT_W-1:0]     out_slot,
  output logic                              out_flag,
  output logic [rcslot_pkg::WORD_W-1:0]     out_x,
  output logic [rcslot_pkg::WORD_W-1:0]     out_y,
  output logic [rcslot_pkg::WORD_W-1:0]     out_z,
  output logic [rcslot_pkg::LIVE_W-1:0]     out_live
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int VEC_W = 3 * rcslot_pkg::WORD_W;

  // Captured command word
  logic [rcslot_pkg::CMD_W-1:0]  cmd_q;
  logic [rcslot_pkg::ID_W-1:0]   id_q;
  logic                          flag_q;
  logic [VEC_W-1:0]              vec_q;

  // Table state in flip-flops
  logic [SLOTS-1:0]              used;
  logic [SLOTS-1:0]              used_next;
  logic [rcslot_pkg::ID_W-1:0]   key [SLOTS];
  logic [rcslot_pkg::LIVE_W-1:0] live;
  logic [rcslot_pkg::LIVE_W-1:0] live_next;

  // Slot memories
  logic [rcslot_pkg::REFS_W-1:0] refs_mem [SLOTS];
  logic                          flag_mem [SLOTS];
  logic [VEC_W-1:0]              vec_mem  [SLOTS];

  // Search and encode results
  logic [SLOTS-1:0]              match_v;
  logic [SLOTS-1:0]              free_v;
  logic                          hit;
  logic [IDX_W-1:0]              hit_idx;
  logic                          free_ok;
  logic [IDX_W-1:0]              free_idx;

  // Registered memory read data
  logic [rcslot_pkg::REFS_W-1:0] rd_refs;
  logic                          rd_flag;
  logic [VEC_W-1:0]              rd_vec;

  // Combinational helpers
  logic                          clear_all;
  logic [SLOTS-1:0]              used_eff;
  logic                          enc_hit;
  logic [IDX_W-1:0]              enc_hit_idx;
  logic                          enc_free_ok;
  logic [IDX_W-1:0]              enc_free_idx;
  logic                          is_reg;
  logic                          is_rel;
  logic                          is_look;
  logic                          do_join;
  logic                          do_create;
  logic                          do_freed;
  logic                          do_decr;
  logic [rcslot_pkg::REFS_W-1:0] refs_dec;
  logic                          refs_we;
  logic [rcslot_pkg::REFS_W-1:0] refs_wd;
  logic                          flag_we;
  logic                          vec_we;
  logic [IDX_W-1:0]              wr_addr;
  logic [IDX_W+2:0]              idx_ext;
  logic [IDX_W-1:0]              res_idx;
  logic [rcslot_pkg::STATUS_W-1:0] res_status;
  logic                          res_has_slot;

  // Capture the command word at accept
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q  <= in_cmd;
      id_q   <= in_id;
      flag_q <= in_flag;
      vec_q  <= {in_z, in_y, in_x};
    end
  end

  // A register with no live ids sees an empty table
  assign clear_all = (cmd_q == rcslot_pkg::CMD_REGISTER) && (live == '0);
  assign used_eff  = clear_all ? '0 : used;

  // Compare the key against every slot in parallel
  always_ff @(posedge clk) begin
    if (dp_cmd.search) begin
      for (int i = 0; i < SLOTS; i++) begin
        match_v[i] <= used_eff[i] && (key[i] == id_q);
      end
      free_v <= ~used_eff;
    end
  end

  // Lowest matching and lowest free slot
  always_comb begin
    enc_hit      = 1'b0;
    enc_hit_idx  = '0;
    enc_free_ok  = 1'b0;
    enc_free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        enc_hit     = 1'b1;
        enc_hit_idx = IDX_W'(i);
      end
      if (free_v[i]) begin
        enc_free_ok  = 1'b1;
        enc_free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.encode) begin
      hit      <= enc_hit;
      hit_idx  <= enc_hit_idx;
      free_ok  <= enc_free_ok;
      free_idx <= enc_free_idx;
    end
  end

  // Read the matching slot
  always_ff @(posedge clk) begin
    if (dp_cmd.read) begin
      rd_refs <= refs_mem[hit_idx];
      rd_flag <= flag_mem[hit_idx];
      rd_vec  <= vec_mem[hit_idx];
    end
  end

  // Decide the update
  assign is_reg    = (cmd_q == rcslot_pkg::CMD_REGISTER);
  assign is_rel    = (cmd_q == rcslot_pkg::CMD_RELEASE);
  assign is_look   = (cmd_q == rcslot_pkg::CMD_LOOKUP);
  assign refs_dec  = (rd_refs != '0) ? rd_refs - 1'b1 : rd_refs;
  assign do_join   = is_reg && hit;
  assign do_create = is_reg && !hit && free_ok;
  assign do_freed  = is_rel && hit && (refs_dec == '0);
  assign do_decr   = is_rel && hit && (refs_dec != '0);

  always_comb begin
    refs_we = 1'b0;
    refs_wd = rd_refs;
    flag_we = 1'b0;
    vec_we  = 1'b0;
    wr_addr = hit_idx;
    if (dp_cmd.commit) begin
      if (do_join) begin
        refs_we = 1'b1;
        refs_wd = (rd_refs != rcslot_pkg::REFS_MAX) ? rd_refs + 1'b1 : rd_refs;
        flag_we = 1'b1;
      end else if (do_create) begin
        refs_we = 1'b1;
        refs_wd = rcslot_pkg::REFS_W'(1);
        flag_we = 1'b1;
        vec_we  = 1'b1;
        wr_addr = free_idx;
      end else if (do_decr) begin
        refs_we = 1'b1;
        refs_wd = refs_dec;
      end
    end
  end

  // Slot memory writes
  always_ff @(posedge clk) begin
    if (refs_we) refs_mem[wr_addr] <= refs_wd;
    if (flag_we) flag_mem[wr_addr] <= flag_q;
    if (vec_we)  vec_mem[wr_addr]  <= vec_q;
  end

  // Key store on create
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && do_create) key[free_idx] <= id_q;
  end

  // Used bits and live count
  always_comb begin
    used_next = used;
    live_next = live;
    if (dp_cmd.search && clear_all) used_next = '0;
    if (dp_cmd.commit && do_create) begin
      used_next[free_idx] = 1'b1;
      if (live != rcslot_pkg::LIVE_MAX) live_next = live + 1'b1;
    end
    if (dp_cmd.commit && do_freed) begin
      used_next[hit_idx] = 1'b0;
      if (live != '0) live_next = live - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      live <= '0;
    end else begin
      used <= used_next;
      live <= live_next;
    end
  end

  // Result status and slot
  always_comb begin
    res_status   = rcslot_pkg::ST_NOTFOUND;
    res_has_slot = 1'b0;
    res_idx      = hit_idx;
    if (is_reg) begin
      if (hit) begin
        res_status   = rcslot_pkg::ST_JOINED;
        res_has_slot = 1'b1;
      end else if (free_ok) begin
        res_status   = rcslot_pkg::ST_CREATED;
        res_has_slot = 1'b1;
        res_idx      = free_idx;
      end else begin
        res_status   = rcslot_pkg::ST_FULL;
      end
    end else if (is_rel && hit) begin
      res_status   = do_freed ? rcslot_pkg::ST_FREED : rcslot_pkg::ST_DECR;
      res_has_slot = 1'b1;
    end else if (is_look && hit) begin
      res_status   = rcslot_pkg::ST_HIT;
      res_has_slot = 1'b1;
    end
  end

  assign idx_ext = {3'b000, res_idx};

  // Result register: load on commit, drop when the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      out_status <= res_status;
      out_slot   <= res_has_slot ? idx_ext[2:0] : '0;
      out_flag   <= (is_look && hit) ? rd_flag : 1'b0;
      out_x      <= (is_look && hit) ? rd_vec[rcslot_pkg::WORD_W-1:0] : '0;
      out_y      <= (is_look && hit) ? rd_vec[2*rcslot_pkg::WORD_W-1:rcslot_pkg::WORD_W] : '0;
      out_z      <= (is_look && hit) ? rd_vec[VEC_W-1:2*rcslot_pkg::WORD_W] : '0;
      out_live   <= live_next;
    end
  end

  assign dp_status.out_free = !out_valid || out_ready;

endmodule

[hw/rtl/refcounted_id_slot_table.sv]
// Reference-counted id slot table, top level.
// Request channel req: one word carries cmd (register, release, look up), id,
// flag and a three-word vector; it is accepted when req.valid and req.ready
// are both high. Response channel rsp: one word per request with status, slot,
// stored flag and vector (look up hits only) and the live id count.
// Each request passes search, encode and memory read, then update and result
// register load together.
// The controller walks each word through the shared compare, the priority
// encoder and the slot memories before taking the next. req.ready is high
// only while idle.
// The result register parts the two sides: the next request is taken while a
// result still waits. If rsp.ready stays low the update of the following
// request holds until the waiting word is taken.
// Reset (rst, synchronous, active high) clears all used bits, the live count,
// the result valid and the controller state. Key, flag, count and vector
// memories need no clearing: slot data counts only while its used bit is set.
// A register command arriving with a live count of zero empties the table
// before it searches.
module refcounted_id_slot_table #(
  parameter int SLOTS = rcslot_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rcslot_req_if.sink    req,
  rcslot_rsp_if.source  rsp
);

  rcslot_pkg::dp_cmd_t    dp_cmd;
  rcslot_pkg::dp_status_t dp_status;

  // Sequence each word
  rcslot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  // Table and result register
  rcslot_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .dp_status  (dp_status),
    .in_cmd     (req.cmd),
    .in_id      (req.id),
    .in_flag    (req.flag),
    .in_x       (req.vec_x),
    .in_y       (req.vec_y),
    .in_z       (req.vec_z),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_status (rsp.status),
    .out_slot   (rsp.slot),
    .out_flag   (rsp.flag_out),
    .out_x      (rsp.out_x),
    .out_y      (rsp.out_y),
    .out_z      (rsp.out_z),
    .out_live   (rsp.live_ids)
  );

endmodule
